// ===== rtl/idr_pkg.sv =====
// shared types and constants of the 64-bit integer divider
`timescale 1ns / 1ps
`default_nettype none
package idr_pkg;

   // operand and result width
   localparam int IDR_WIDTH = 64;

   // operation codes
   typedef enum logic [1:0] {
      CMD_UDIV = 2'd0,
      CMD_UREM = 2'd1,
      CMD_SDIV = 2'd2,
      CMD_SREM = 2'd3
   } idr_cmd_type;

   // one item in flight through the divide pipeline
   typedef struct packed {
      idr_cmd_type          cmd;
      logic                 nneg;
      logic                 dneg;
      logic                 dz;
      logic [IDR_WIDTH-1:0] rem;
      logic [IDR_WIDTH-1:0] quo;
      logic [IDR_WIDTH-1:0] dvs;
   } idr_work_type;

endpackage
`default_nettype wire

// ===== rtl/idr_ifs.sv =====
// request and response channel interfaces of the divider
`timescale 1ns / 1ps
`default_nettype none
interface idr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [63:0] dividend;
   logic [63:0] divisor;

   modport source (output valid, output command, output dividend, output divisor,
                   input ready);
   modport sink (input valid, input command, input dividend, input divisor,
                 output ready);
endinterface

interface idr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] answer;
   logic        divide_by_zero;

   modport source (output valid, output answer, output divide_by_zero, input ready);
   modport sink (input valid, input answer, input divide_by_zero, output ready);
endinterface
`default_nettype wire

// ===== rtl/idr_prep.sv =====
// entry stage: operand magnitudes, sign flags and zero divisor check
`timescale 1ns / 1ps
`default_nettype none
module idr_prep (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                advance,
   input  wire                                in_valid,
   input  wire  [1:0]                         in_command,
   input  wire  [idr_pkg::IDR_WIDTH-1:0]      in_dividend,
   input  wire  [idr_pkg::IDR_WIDTH-1:0]      in_divisor,
   output logic                               out_valid,
   output idr_pkg::idr_work_type              out_work
);

   logic                  valid_ff;
   idr_pkg::idr_work_type work_ff;
   idr_pkg::idr_work_type work_in;
   idr_pkg::idr_cmd_type  cmd;
   logic                  is_signed;

   // sign handling: signed commands work on magnitudes
   always_comb begin
      cmd          = idr_pkg::idr_cmd_type'(in_command);
      is_signed    = (cmd == idr_pkg::CMD_SDIV) || (cmd == idr_pkg::CMD_SREM);
      work_in.cmd  = cmd;
      work_in.nneg = is_signed && in_dividend[idr_pkg::IDR_WIDTH-1];
      work_in.dneg = is_signed && in_divisor[idr_pkg::IDR_WIDTH-1];
      work_in.dz   = (in_divisor == '0);
      work_in.rem  = '0;
      work_in.quo  = work_in.nneg ? (~in_dividend + 1'b1) : in_dividend;
      work_in.dvs  = work_in.dneg ? (~in_divisor + 1'b1) : in_divisor;
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule
`default_nettype wire

// ===== rtl/idr_step.sv =====
// one restoring divide step: shift in a dividend bit, trial subtract
`timescale 1ns / 1ps
`default_nettype none
module idr_step (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                advance,
   input  wire                                in_valid,
   input  idr_pkg::idr_work_type              in_work,
   output logic                               out_valid,
   output idr_pkg::idr_work_type              out_work
);

   logic                           valid_ff;
   idr_pkg::idr_work_type          work_ff;
   idr_pkg::idr_work_type          work_in;
   logic [idr_pkg::IDR_WIDTH+1:0]  trial;
   logic                           fits;

   // partial remainder times two plus next dividend bit, minus divisor
   always_comb begin
      trial = {1'b0, in_work.rem, in_work.quo[idr_pkg::IDR_WIDTH-1]}
            - {2'b00, in_work.dvs};
      fits  = ~trial[idr_pkg::IDR_WIDTH+1];
      work_in     = in_work;
      work_in.rem = fits ? trial[idr_pkg::IDR_WIDTH-1:0]
                         : {in_work.rem[idr_pkg::IDR_WIDTH-2:0],
                            in_work.quo[idr_pkg::IDR_WIDTH-1]};
      work_in.quo = {in_work.quo[idr_pkg::IDR_WIDTH-2:0], fits};
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule
`default_nettype wire

// ===== rtl/idr_fix.sv =====
// exit stage: result select, sign restore and response register
`timescale 1ns / 1ps
`default_nettype none
module idr_fix (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                advance,
   input  wire                                in_valid,
   input  idr_pkg::idr_work_type              in_work,
   output logic                               out_valid,
   output logic [idr_pkg::IDR_WIDTH-1:0]      out_answer,
   output logic                               out_dz
);

   logic                          valid_ff;
   logic [idr_pkg::IDR_WIDTH-1:0] answer_ff;
   logic [idr_pkg::IDR_WIDTH-1:0] answer_in;
   logic                          dz_ff;

   // pick quotient or remainder and apply the sign
   always_comb begin
      unique case (in_work.cmd)
         idr_pkg::CMD_UDIV: answer_in = in_work.quo;
         idr_pkg::CMD_UREM: answer_in = in_work.rem;
         idr_pkg::CMD_SDIV: answer_in = (in_work.nneg ^ in_work.dneg)
                                        ? (~in_work.quo + 1'b1) : in_work.quo;
         idr_pkg::CMD_SREM: answer_in = in_work.nneg ? (~in_work.rem + 1'b1)
                                                     : in_work.rem;
         default:           answer_in = '0;
      endcase
      if (in_work.dz) begin
         answer_in = '0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         answer_ff <= answer_in;
         dz_ff     <= in_work.dz;
      end
   end

   assign out_valid  = valid_ff;
   assign out_answer = answer_ff;
   assign out_dz     = dz_ff;

endmodule
`default_nettype wire

// ===== rtl/int64_divide_remainder_top.sv =====
// top level of the pipelined 64-bit signed and unsigned divider
//
// Requests come in on req (command, dividend, divisor) with valid/ready; one
// response per request leaves on rsp (answer, divide_by_zero) in order.
// Commands: unsigned quotient, unsigned remainder, signed quotient, signed
// remainder. Signed results truncate toward zero; a zero divisor gives an
// answer of 0 with divide_by_zero set.
// A request passes one entry stage that takes operand magnitudes, 64
// restoring steps of one quotient bit each (one 66-bit trial subtract per
// stage), and one exit stage that restores signs into the response
// register.
// Throughput is one request per cycle while the receiver takes responses.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and req.ready drops; bubbles move on while the response register is empty.
// Synchronous reset clears all valid bits; no request is in flight after it.
`timescale 1ns / 1ps
`default_nettype none
module int64_divide_remainder_top (
   input  wire            clock,
   input  wire            reset,
   idr_req_if.sink        req,
   idr_rsp_if.source      rsp
);

   localparam int STEPS = idr_pkg::IDR_WIDTH;

   logic                  advance;
   logic                  rsp_valid;
   logic                  step_valid [0:STEPS];
   idr_pkg::idr_work_type step_work  [0:STEPS];

   // whole pipeline moves unless a response is stuck
   assign advance   = !rsp_valid || rsp.ready;
   assign req.ready = advance;

   // operand preparation
   idr_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req.valid),
      .in_command  (req.command),
      .in_dividend (req.dividend),
      .in_divisor  (req.divisor),
      .out_valid   (step_valid[0]),
      .out_work    (step_work[0])
   );

   // restoring divide chain, one quotient bit per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      idr_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (step_valid[i]),
         .in_work   (step_work[i]),
         .out_valid (step_valid[i+1]),
         .out_work  (step_work[i+1])
      );
   end

   // result fix-up and response register
   idr_fix u_fix (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (step_valid[STEPS]),
      .in_work    (step_work[STEPS]),
      .out_valid  (rsp_valid),
      .out_answer (rsp.answer),
      .out_dz     (rsp.divide_by_zero)
   );

   assign rsp.valid = rsp_valid;

endmodule
`default_nettype wire

// ===== dv/int64_divide_remainder_top_tb.sv =====
// self-checking testbench of the 64-bit signed and unsigned divider
`timescale 1ns / 1ps
module int64_divide_remainder_top_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

   // one expected response
   typedef struct packed {
      logic [63:0] answer;
      logic        divide_by_zero;
   } div_answer_type;

   logic clock;
   logic reset;

   idr_req_if req_ch ();
   idr_rsp_if rsp_ch ();

   int64_divide_remainder_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   div_answer_type pending_answers[$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   bit             sender_gaps = 1'b1;
   bit             rx_always_ready = 1'b0;
   int             rx_mode = 0;
   int             rx_hold_left = 0;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // quotient or remainder with sign handling and zero-divisor flag
   function automatic div_answer_type predict_division(idr_pkg::idr_cmd_type cmd,
                                                       logic [63:0] num,
                                                       logic [63:0] den);
      div_answer_type res;
      logic [63:0] num_mag;
      logic [63:0] den_mag;
      logic [63:0] part;
      res = '0;
      num_mag = num[63] ? 64'd0 - num : num;
      den_mag = den[63] ? 64'd0 - den : den;
      if (den == 64'd0) begin
         res.divide_by_zero = 1'b1;
      end else begin
         case (cmd)
            idr_pkg::CMD_UDIV: res.answer = num / den;
            idr_pkg::CMD_UREM: res.answer = num % den;
            idr_pkg::CMD_SDIV: begin
               part = num_mag / den_mag;
               res.answer = (num[63] ^ den[63]) ? 64'd0 - part : part;
            end
            default: begin
               part = num_mag % den_mag;
               res.answer = num[63] ? 64'd0 - part : part;
            end
         endcase
      end
      return res;
   endfunction

   // operand drawn from a mix of extremes, small values and wide patterns
   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0: v = 64'd0;
         1: v = ALL_ONES;
         2: v = MOST_NEG;
         3: v = MOST_POS;
         4: v = 64'($urandom_range(1, 20));
         5: v = 64'd0 - 64'($urandom_range(1, 20));
         6: v = v >> $urandom_range(1, 63);
         7: v = 64'd1 << $urandom_range(0, 63);
         8: v = 64'd0 - (v >> $urandom_range(1, 63));
         default: ;
      endcase
      return v;
   endfunction

   // send one request, bursts separated by random gaps when enabled
   task automatic send_divide(input idr_pkg::idr_cmd_type cmd, input logic [63:0] num,
                              input logic [63:0] den);
      if (sender_gaps && burst_left == 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_ch.valid    <= 1'b1;
      req_ch.command  <= cmd;
      req_ch.dividend <= num;
      req_ch.divisor  <= den;
      do @(posedge clock); while (!req_ch.ready);
      pending_answers.push_back(predict_division(cmd, num, den));
      if (burst_left > 0) burst_left--;
   endtask

   // drop valid and wait for every outstanding response
   task automatic wait_all_answered();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // zero divisor, most negative by minus one, truncation signs, extremes
   task automatic test_directed_cases();
      send_divide(idr_pkg::CMD_UDIV, 64'd0, 64'd0);
      send_divide(idr_pkg::CMD_UREM, ALL_ONES, 64'd0);
      send_divide(idr_pkg::CMD_SDIV, MOST_NEG, 64'd0);
      send_divide(idr_pkg::CMD_SREM, 64'd123, 64'd0);
      send_divide(idr_pkg::CMD_SDIV, MOST_NEG, ALL_ONES);
      send_divide(idr_pkg::CMD_SREM, MOST_NEG, ALL_ONES);
      send_divide(idr_pkg::CMD_UDIV, MOST_NEG, ALL_ONES);
      send_divide(idr_pkg::CMD_UREM, MOST_NEG, ALL_ONES);
      send_divide(idr_pkg::CMD_SDIV, 64'd0 - 64'd7, 64'd2);
      send_divide(idr_pkg::CMD_SDIV, 64'd7, 64'd0 - 64'd2);
      send_divide(idr_pkg::CMD_SDIV, 64'd0 - 64'd7, 64'd0 - 64'd2);
      send_divide(idr_pkg::CMD_SREM, 64'd0 - 64'd7, 64'd2);
      send_divide(idr_pkg::CMD_SREM, 64'd7, 64'd0 - 64'd2);
      send_divide(idr_pkg::CMD_SREM, 64'd0 - 64'd7, 64'd0 - 64'd2);
      send_divide(idr_pkg::CMD_UDIV, ALL_ONES, 64'd1);
      send_divide(idr_pkg::CMD_UREM, ALL_ONES, ALL_ONES);
      send_divide(idr_pkg::CMD_UDIV, 64'd0, ALL_ONES);
      send_divide(idr_pkg::CMD_SDIV, MOST_NEG, 64'd1);
      send_divide(idr_pkg::CMD_SREM, MOST_POS, MOST_NEG);
      send_divide(idr_pkg::CMD_UDIV, ALL_ONES, 64'd1 << 32);
      send_divide(idr_pkg::CMD_UREM, MOST_NEG, ALL_ONES - 64'd1);
      send_divide(idr_pkg::CMD_SDIV, MOST_NEG, MOST_NEG);
      wait_all_answered();
   endtask

   // random commands and operands with sender bursts and gaps
   task automatic test_random_bursts(input int count);
      logic [63:0] num;
      logic [63:0] den;
      for (int i = 0; i < count; i++) begin
         num = random_operand();
         den = random_operand();
         // divisor near the dividend now and then
         if ($urandom_range(0, 7) == 0) den = num + 64'($urandom_range(0, 3));
         send_divide(idr_pkg::idr_cmd_type'($urandom_range(0, 3)), num, den);
      end
   endtask

   // sender holds off until the pipeline is empty, then resumes
   task automatic test_drain_pause();
      test_random_bursts(50);
      wait_all_answered();
      test_random_bursts(50);
      wait_all_answered();
   endtask

   // no sender gaps; receiver always ready for a stretch, then its own pattern
   task automatic test_back_to_back();
      sender_gaps = 1'b0;
      rx_always_ready = 1'b1;
      test_random_bursts(80);
      rx_always_ready = 1'b0;
      test_random_bursts(80);
      sender_gaps = 1'b1;
      wait_all_answered();
   endtask

   // receiver stall pattern: modes held for random stretches
   always @(negedge clock) begin
      logic take;
      if (rx_hold_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_hold_left = $urandom_range(16, 96);
      end
      rx_hold_left--;
      case (rx_mode)
         0: take = 1'b1;
         1: take = ($urandom_range(0, 3) != 0);
         2: take = ($urandom_range(0, 3) == 0);
         default: take = ((rx_hold_left % 12) >= 5);
      endcase
      rsp_ch.ready <= rx_always_ready | take;
   end

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      div_answer_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t unexpected response: answer %h divide_by_zero %b", $time,
                     rsp_ch.answer, rsp_ch.divide_by_zero);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_ch.answer !== want.answer) begin
               $display("%0t answer mismatch: expected %h actual %h", $time,
                        want.answer, rsp_ch.answer);
               error_count++;
            end
            if (rsp_ch.divide_by_zero !== want.divide_by_zero) begin
               $display("%0t divide_by_zero mismatch: expected %b actual %b", $time,
                        want.divide_by_zero, rsp_ch.divide_by_zero);
               error_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // reset, tests in turn, final verdict
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = idr_pkg::CMD_UDIV;
      req_ch.dividend = 64'd0;
      req_ch.divisor = 64'd0;
      rsp_ch.ready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_bursts(240);
      wait_all_answered();
      test_drain_pause();
      test_back_to_back();

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
